[rtl/tdrm_pkg.sv]
// Package for the tag distance running mean unit.
// Shared widths, types and constants; no dependencies.
package tdrm_pkg;

    localparam int NUM_TAGS = 4;
    localparam int TAG_W    = 2;
    localparam int COORD_W  = 24;
    // Coordinate difference and its magnitude
    localparam int DIFF_W   = COORD_W + 1;
    // Sum of two squared magnitudes, one spare bit on top
    localparam int SQ_W     = 2 * DIFF_W + 1;
    localparam int DIST_W   = 25;
    localparam int CNT_W    = 16;
    // Root remainder: up to twice the root, shifted by one pair
    localparam int REM_W    = DIST_W + 3;
    // Rounded numerator of the mean update
    localparam int NUM_W    = DIST_W + 1;
    localparam int STEP_W   = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = {CNT_W{1'b1}};

    typedef logic [TAG_W-1:0]          tag_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIFF_W-1:0]         mag_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [NUM_W-1:0]          num_t;

endpackage

[rtl/tag_distance_running_mean_unit.sv]
// Tag distance running mean: top level with per-tag mean and count state.
// Depends on tdrm_pkg, tdrm_dist_unit and tdrm_div_unit.
//
// Input channel s_*: one transfer carries the reference and tag positions
// (signed Q8.16) with presence flags and the tag index. Output channel m_*:
// tag index, this item's distance, the tag's running mean and a flag that
// the tag has been sampled. Items with the reference absent give no result.
// cfg_wr_en/cfg_wr_data write max_samples; write it only while idle.
//
// One item is in work at a time. The distance runs the serial squarer, then
// the serial root, then a rounding step. With the tag absent the result then
// goes to the output stage; with the tag present the 26-step serial divider
// runs first to update the tag's mean.
// s_ready is high only while no item is in work; a dropped item is not taken
// into work, so the input stays ready.
// Results sit in an output register: when the receiver stalls, the next item
// is still taken and computed, and waits only for that register to empty.
// Reset (aresetn low, synchronous) clears all means and counts, sets
// max_samples to 65535 and empties the output register.
module tag_distance_running_mean_unit (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  tdrm_pkg::cnt_t         cfg_wr_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  tdrm_pkg::coord_t       s_ref_x,
    input  tdrm_pkg::coord_t       s_ref_y,
    input  logic                   s_ref_present,
    input  tdrm_pkg::coord_t       s_tag_x,
    input  tdrm_pkg::coord_t       s_tag_y,
    input  logic                   s_tag_present,
    input  tdrm_pkg::tag_t         s_tag_index,

    output logic                   m_valid,
    input  logic                   m_ready,
    output tdrm_pkg::tag_t         m_out_tag,
    output tdrm_pkg::dist_t        m_sample_dist,
    output tdrm_pkg::dist_t        m_filtered_distance,
    output logic                   m_filtered_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIST = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int DW = tdrm_pkg::DIFF_W;
    localparam int LW = tdrm_pkg::DIST_W;
    localparam int CW = tdrm_pkg::CNT_W;

    logic [1:0]       state_reg, state_next;
    tdrm_pkg::cnt_t   max_samples_reg, max_samples_next;
    tdrm_pkg::dist_t  mean_reg  [tdrm_pkg::NUM_TAGS];
    tdrm_pkg::dist_t  mean_next [tdrm_pkg::NUM_TAGS];
    tdrm_pkg::cnt_t   count_reg [tdrm_pkg::NUM_TAGS];
    tdrm_pkg::cnt_t   count_next[tdrm_pkg::NUM_TAGS];
    tdrm_pkg::tag_t   tag_reg, tag_next;
    logic             tag_present_reg, tag_present_next;
    logic             neg_reg, neg_next;
    tdrm_pkg::dist_t  dist_reg, dist_next;

    logic             m_valid_reg, m_valid_next;
    tdrm_pkg::tag_t   m_tag_reg, m_tag_next;
    tdrm_pkg::dist_t  m_meas_reg, m_meas_next;
    tdrm_pkg::dist_t  m_filt_reg, m_filt_next;
    logic             m_fvalid_reg, m_fvalid_next;

    logic             s_xfer;
    logic             take_item;
    logic [DW-1:0]    dx, dy;
    tdrm_pkg::mag_t   mag_x, mag_y;
    logic             dist_start, dist_done;
    tdrm_pkg::dist_t  dist_value;
    logic             div_start, div_done;
    tdrm_pkg::num_t   div_num, div_quo;
    tdrm_pkg::cnt_t   div_den;
    tdrm_pkg::cnt_t   cur_count, limit, n_value;
    tdrm_pkg::dist_t  cur_mean;
    logic [LW:0]      diff;
    tdrm_pkg::dist_t  abs_diff;
    logic             out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign take_item = s_xfer && s_ref_present && (int'(s_tag_index) < tdrm_pkg::NUM_TAGS);

    always_comb begin
        dx    = {s_tag_x[tdrm_pkg::COORD_W-1], s_tag_x} - {s_ref_x[tdrm_pkg::COORD_W-1], s_ref_x};
        dy    = {s_tag_y[tdrm_pkg::COORD_W-1], s_tag_y} - {s_ref_y[tdrm_pkg::COORD_W-1], s_ref_y};
        mag_x = dx[DW-1] ? -dx : dx;
        mag_y = dy[DW-1] ? -dy : dy;
    end

    assign dist_start = take_item;

    tdrm_dist_unit u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dist_start),
        .mag_x    (mag_x),
        .mag_y    (mag_y),
        .done     (dist_done),
        .distance (dist_value)
    );

    tdrm_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        cur_count = count_reg[tag_reg];
        cur_mean  = mean_reg[tag_reg];
        // a zero limit behaves as one
        limit     = (max_samples_reg == '0) ? CW'(1) : max_samples_reg;
        n_value   = (cur_count < limit) ? cur_count + 1'b1 : cur_count;
        diff      = {1'b0, dist_value} - {1'b0, cur_mean};
        abs_diff  = diff[LW] ? LW'(-diff) : diff[LW-1:0];
        // quotient rounded half away from zero: add n/2 to the magnitude
        div_num   = {1'b0, abs_diff} + {{(tdrm_pkg::NUM_W-CW+1){1'b0}}, n_value[CW-1:1]};
        div_den   = n_value;
        out_free  = !m_valid_reg || m_ready;
    end

    assign div_start = (state_reg == ST_DIST) && dist_done && tag_present_reg;

    always_comb begin
        state_next       = state_reg;
        max_samples_next = cfg_wr_en ? cfg_wr_data : max_samples_reg;
        mean_next        = mean_reg;
        count_next       = count_reg;
        tag_next         = tag_reg;
        tag_present_next = tag_present_reg;
        neg_next         = neg_reg;
        dist_next        = dist_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_tag_next    = m_tag_reg;
        m_meas_next   = m_meas_reg;
        m_filt_next   = m_filt_reg;
        m_fvalid_next = m_fvalid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (take_item) begin
                    tag_next         = s_tag_index;
                    tag_present_next = s_tag_present;
                    state_next       = ST_DIST;
                end
            end
            ST_DIST: begin
                if (dist_done) begin
                    dist_next = dist_value;
                    if (tag_present_reg) begin
                        count_next[tag_reg] = n_value;
                        neg_next            = diff[LW];
                        state_next          = ST_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mean_next[tag_reg] = neg_reg ? cur_mean - div_quo[LW-1:0]
                                                 : cur_mean + div_quo[LW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_tag_next    = tag_reg;
                    m_meas_next   = dist_reg;
                    m_filt_next   = (cur_count != '0) ? cur_mean : '0;
                    m_fvalid_next = (cur_count != '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_samples_reg <= tdrm_pkg::CNT_RESET;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < tdrm_pkg::NUM_TAGS; i++) begin
                mean_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            max_samples_reg <= max_samples_next;
            m_valid_reg     <= m_valid_next;
            mean_reg        <= mean_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg         <= tag_next;
        tag_present_reg <= tag_present_next;
        neg_reg         <= neg_next;
        dist_reg        <= dist_next;
        m_tag_reg       <= m_tag_next;
        m_meas_reg      <= m_meas_next;
        m_filt_reg      <= m_filt_next;
        m_fvalid_reg    <= m_fvalid_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_out_tag           = m_tag_reg;
    assign m_sample_dist       = m_meas_reg;
    assign m_filtered_distance = m_filt_reg;
    assign m_filtered_valid    = m_fvalid_reg;

endmodule

[rtl/tdrm_dist_unit.sv]
// Bit-serial planar distance: squares both magnitudes with a shift-add
// multiplier, then takes the rounded square root one pair per cycle.
// Depends on tdrm_pkg.
module tdrm_dist_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  tdrm_pkg::mag_t   mag_x,
    input  tdrm_pkg::mag_t   mag_y,
    output logic             done,
    output tdrm_pkg::dist_t  distance
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQ   = 2'd1;
    localparam logic [1:0] PH_RT   = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    localparam int DW = tdrm_pkg::DIFF_W;
    localparam int SW = tdrm_pkg::SQ_W;
    localparam int RW = tdrm_pkg::REM_W;
    localparam int LW = tdrm_pkg::DIST_W;
    localparam logic [tdrm_pkg::STEP_W-1:0] LAST_STEP = tdrm_pkg::STEP_W'(DW - 1);

    logic [1:0]                  phase_reg, phase_next;
    logic [tdrm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        done_reg, done_next;
    tdrm_pkg::mag_t              mcand_x_reg, mcand_x_next;
    tdrm_pkg::mag_t              mcand_y_reg, mcand_y_next;
    tdrm_pkg::mag_t              mx_reg, mx_next;
    tdrm_pkg::mag_t              my_reg, my_next;
    logic [SW-1:0]               p_reg, p_next;
    logic [RW-1:0]               rem_reg, rem_next;
    tdrm_pkg::dist_t             root_reg, root_next;
    tdrm_pkg::dist_t             dist_reg, dist_next;

    logic [DW:0]   addend;
    logic [DW+1:0] psum;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          fits;

    always_comb begin
        addend = (mx_reg[0] ? {1'b0, mcand_x_reg} : '0)
               + (my_reg[0] ? {1'b0, mcand_y_reg} : '0);
        psum   = {1'b0, p_reg[SW-1:DW]} + {1'b0, addend};
        rem_sh = {rem_reg[RW-3:0], p_reg[SW-2:SW-3]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;

        phase_next   = phase_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        mcand_x_next = mcand_x_reg;
        mcand_y_next = mcand_y_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        dist_next    = dist_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    mcand_x_next = mag_x;
                    mcand_y_next = mag_y;
                    mx_next      = mag_x;
                    my_next      = mag_y;
                    p_next       = '0;
                    step_next    = '0;
                    phase_next   = PH_SQ;
                end
            end
            PH_SQ: begin
                // right-shift product: add at the top, retire one bit at the bottom
                p_next  = {psum, p_reg[DW-1:1]};
                mx_next = {1'b0, mx_reg[DW-1:1]};
                my_next = {1'b0, my_reg[DW-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    phase_next = PH_RT;
                end
            end
            PH_RT: begin
                // restoring root, two radicand bits per step (top bit is always zero)
                p_next = {p_reg[SW-3:0], 2'b00};
                if (fits) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[LW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[LW-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    phase_next = PH_FIN;
                end
            end
            PH_FIN: begin
                // round to nearest
                dist_next  = (rem_reg > {{(RW-LW){1'b0}}, root_reg}) ? root_reg + 1'b1
                                                                     : root_reg;
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_x_reg <= mcand_x_next;
        mcand_y_reg <= mcand_y_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        dist_reg    <= dist_next;
    end

    assign done     = done_reg;
    assign distance = dist_reg;

endmodule

[rtl/tdrm_div_unit.sv]
// Bit-serial restoring divider for the mean update step.
// Depends on tdrm_pkg.
module tdrm_div_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  tdrm_pkg::num_t  num,
    input  tdrm_pkg::cnt_t  den,
    output logic            done,
    output tdrm_pkg::num_t  quo
);

    localparam int NW = tdrm_pkg::NUM_W;
    localparam int CW = tdrm_pkg::CNT_W;
    localparam logic [tdrm_pkg::STEP_W-1:0] LAST_STEP = tdrm_pkg::STEP_W'(NW - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [tdrm_pkg::STEP_W-1:0] step_reg, step_next;
    tdrm_pkg::num_t              q_reg, q_next;
    tdrm_pkg::cnt_t              r_reg, r_next;
    tdrm_pkg::cnt_t              den_reg, den_next;

    logic [CW:0] r_sh;
    logic [CW:0] r_sub;
    logic        ge;

    always_comb begin
        r_sh  = {r_reg, q_reg[NW-1]};
        r_sub = r_sh - {1'b0, den_reg};
        ge    = r_sh >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        den_next  = den_reg;

        if (busy_reg) begin
            // numerator bits leave at the top, quotient bits enter at the bottom
            q_next    = {q_reg[NW-2:0], ge};
            r_next    = ge ? r_sub[CW-1:0] : r_sh[CW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            q_next    = num;
            r_next    = '0;
            den_next  = den;
            step_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[dv/tdrm_checker.sv]
// Result checker for tag_distance_running_mean_unit: watches both channels
// and the max_samples write port, predicts each result and compares it.
// Depends on tdrm_pkg.
module tdrm_checker (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  tdrm_pkg::cnt_t         cfg_wr_data,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  tdrm_pkg::coord_t       s_ref_x,
    input  tdrm_pkg::coord_t       s_ref_y,
    input  logic                   s_ref_present,
    input  tdrm_pkg::coord_t       s_tag_x,
    input  tdrm_pkg::coord_t       s_tag_y,
    input  logic                   s_tag_present,
    input  tdrm_pkg::tag_t         s_tag_index,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  tdrm_pkg::tag_t         m_out_tag,
    input  tdrm_pkg::dist_t        m_sample_dist,
    input  tdrm_pkg::dist_t        m_filtered_distance,
    input  logic                   m_filtered_valid,

    output int                     fail_count,
    output int                     pending
);
    import tdrm_pkg::*;

    localparam logic [63:0] DIST_SAT = (64'd1 << DIST_W) - 64'd1;

    typedef struct packed {
        tag_t  tag;
        dist_t measured;
        dist_t filtered;
        logic  sampled;
    } tag_result_t;

    tag_result_t result_q[$];
    dist_t       mean_dist [NUM_TAGS];
    cnt_t        sample_cnt [NUM_TAGS];
    cnt_t        max_samples;
    int          errors;

    // Bit-serial integer root of dx^2 + dy^2, rounded to nearest.
    function automatic dist_t planar_distance(coord_t rx, coord_t ry, coord_t tx, coord_t ty);
        longint      dx;
        longint      dy;
        logic [63:0] sum_sq;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sum_sq = dx * dx + dy * dy;
        rem    = '0;
        root   = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((sum_sq >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        // rem = s - r^2; past r means nearer to r+1
        if (rem > root) root = root + 64'd1;
        if (root > DIST_SAT) root = DIST_SAT;
        return dist_t'(root);
    endfunction

    function automatic tag_result_t update_running_mean(coord_t rx, coord_t ry, coord_t tx,
                                                        coord_t ty, logic tp, tag_t ti);
        dist_t           d;
        cnt_t            lim;
        longint          diff;
        longint unsigned ad;
        longint unsigned n;
        longint unsigned q;
        tag_result_t     r;
        d = planar_distance(rx, ry, tx, ty);
        if (tp) begin
            lim = (max_samples == '0) ? cnt_t'(1) : max_samples;
            // a count left above a lowered limit stays as it is
            if (sample_cnt[ti] < lim) sample_cnt[ti] = sample_cnt[ti] + cnt_t'(1);
            n    = sample_cnt[ti];
            diff = longint'(d) - longint'(mean_dist[ti]);
            ad   = (diff < 0) ? -diff : diff;
            q    = (ad + n / 2) / n;
            if (diff < 0)
                mean_dist[ti] = dist_t'(mean_dist[ti] - q);
            else
                mean_dist[ti] = dist_t'(mean_dist[ti] + q);
        end
        r.tag      = ti;
        r.measured = d;
        r.sampled  = (sample_cnt[ti] != '0);
        r.filtered = r.sampled ? mean_dist[ti] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        tag_result_t exp_r;
        tag_result_t new_r;
        if (!aresetn) begin
            for (int i = 0; i < NUM_TAGS; i++) begin
                mean_dist[i]  = '0;
                sample_cnt[i] = '0;
            end
            max_samples = CNT_RESET;
            result_q.delete();
            errors = 0;
        end else begin
            // compare before queuing: a result never belongs to this edge's input
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result transfer for tag %0d", m_out_tag);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_out_tag !== exp_r.tag) begin
                        $error("out_tag: expected %0d, got %0d", exp_r.tag, m_out_tag);
                        errors++;
                    end
                    if (m_sample_dist !== exp_r.measured) begin
                        $error("sample_dist: expected %0d, got %0d",
                               exp_r.measured, m_sample_dist);
                        errors++;
                    end
                    if (m_filtered_distance !== exp_r.filtered) begin
                        $error("filtered_distance: expected %0d, got %0d",
                               exp_r.filtered, m_filtered_distance);
                        errors++;
                    end
                    if (m_filtered_valid !== exp_r.sampled) begin
                        $error("filtered_valid: expected %0d, got %0d",
                               exp_r.sampled, m_filtered_valid);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) max_samples = cfg_wr_data;
            if (s_valid && s_ready && s_ref_present && int'(s_tag_index) < NUM_TAGS) begin
                new_r = update_running_mean(s_ref_x, s_ref_y, s_tag_x, s_tag_y,
                                            s_tag_present, s_tag_index);
                result_q.insert(result_q.size(), new_r);
            end
        end
        fail_count <= errors;
        pending    <= result_q.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top for tag_distance_running_mean_unit: clock, reset, stimulus,
// max_samples phases, receiver stalls and the verdict.
// Depends on tdrm_pkg, tdrm_checker and the unit itself.
module tb_top;
    import tdrm_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN       = 150;
    localparam int     HOLD_CYCLES = 600;
    localparam coord_t C_MAX       = 24'sh7FFFFF;
    localparam coord_t C_MIN       = 24'sh800000;

    logic   aclk;
    logic   aresetn;
    logic   cfg_wr_en;
    cnt_t   cfg_wr_data;
    logic   s_valid;
    logic   s_ready;
    coord_t s_ref_x;
    coord_t s_ref_y;
    logic   s_ref_present;
    coord_t s_tag_x;
    coord_t s_tag_y;
    logic   s_tag_present;
    tag_t   s_tag_index;
    logic   m_valid;
    logic   m_ready;
    tag_t   m_out_tag;
    dist_t  m_sample_dist;
    dist_t  m_filtered_distance;
    logic   m_filtered_valid;
    int     fail_count;
    int     pending;
    int     cycle_count = 0;
    bit     quiet;
    bit     hold_req;

    // max_samples per random phase; the entry at index 4 is drawn at run time
    cnt_t plan_cfg [6]   = '{16'd0, 16'd3, 16'd65535, 16'd1, 16'd0, 16'd2};
    int   plan_items [6] = '{60, 70, 110, 40, 110, 60};

    tag_distance_running_mean_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_ref_x             (s_ref_x),
        .s_ref_y             (s_ref_y),
        .s_ref_present       (s_ref_present),
        .s_tag_x             (s_tag_x),
        .s_tag_y             (s_tag_y),
        .s_tag_present       (s_tag_present),
        .s_tag_index         (s_tag_index),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_tag           (m_out_tag),
        .m_sample_dist       (m_sample_dist),
        .m_filtered_distance (m_filtered_distance),
        .m_filtered_valid    (m_filtered_valid)
    );

    tdrm_checker u_mean_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_ref_x             (s_ref_x),
        .s_ref_y             (s_ref_y),
        .s_ref_present       (s_ref_present),
        .s_tag_x             (s_tag_x),
        .s_tag_y             (s_tag_y),
        .s_tag_present       (s_tag_present),
        .s_tag_index         (s_tag_index),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_tag           (m_out_tag),
        .m_sample_dist       (m_sample_dist),
        .m_filtered_distance (m_filtered_distance),
        .m_filtered_valid    (m_filtered_valid),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return coord_t'(int'($urandom_range(0, 1023)) - 512);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Offers one item and returns at the edge of its transfer, or after a
    // sender gap with valid low if one is drawn; else valid stays up.
    task automatic send_item(input coord_t rx, input coord_t ry, input logic rp,
                             input coord_t tx, input coord_t ty, input logic tp,
                             input tag_t ti);
        s_ref_x       <= rx;
        s_ref_y       <= ry;
        s_ref_present <= rp;
        s_tag_x       <= tx;
        s_tag_y       <= ty;
        s_tag_present <= tp;
        s_tag_index   <= ti;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_random_item();
        coord_t rx;
        coord_t ry;
        coord_t tx;
        coord_t ty;
        int     off_x;
        int     off_y;
        rx = rand_coord();
        ry = rand_coord();
        // mostly a tag within a few metres of the reference
        if ($urandom_range(0, 9) < 7) begin
            off_x = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            off_y = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            tx    = coord_t'(int'(rx) + off_x);
            ty    = coord_t'(int'(ry) + off_y);
        end else begin
            tx = rand_coord();
            ty = rand_coord();
        end
        send_item(rx, ry, $urandom_range(0, 99) < 85, tx, ty, $urandom_range(0, 99) < 85,
                  tag_t'($urandom_range(0, NUM_TAGS - 1)));
    endtask

    // Register write only once the unit has gone idle.
    task automatic write_max_samples(input cnt_t value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random stall bursts, one long hold-off, none when quiet.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready   <= 1'b0;
                hold_done = 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** tag_distance_running_mean_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        cnt_t setting;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_ref_x       = '0;
        s_ref_y       = '0;
        s_ref_present = 1'b0;
        s_tag_x       = '0;
        s_tag_y       = '0;
        s_tag_present = 1'b0;
        s_tag_index   = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, max_samples at its reset value
        send_item('0, '0, 1'b0, '0, '0, 1'b1, 2'd0);                  // reference absent
        send_item(24'sd100, 24'sd200, 1'b1, 24'sd300, 24'sd400, 1'b0, 2'd3); // never sampled
        send_item(C_MIN, C_MIN, 1'b1, C_MAX, C_MAX, 1'b1, 2'd0);      // largest distance
        send_item(C_MAX, C_MAX, 1'b1, C_MIN, C_MIN, 1'b1, 2'd0);
        send_item(C_MAX, C_MIN, 1'b1, C_MIN, C_MAX, 1'b1, 2'd1);
        send_item(24'sd12345, -24'sd6789, 1'b1, 24'sd12345, -24'sd6789, 1'b1, 2'd1); // zero
        send_item('0, '0, 1'b1, -24'sd65536, '0, 1'b1, 2'd2);
        send_item('0, '0, 1'b1, '0, 24'sd196608, 1'b1, 2'd2);
        send_item('0, '0, 1'b1, 24'sd1, 24'sd1, 1'b1, 2'd2);           // root of two
        send_item('0, '0, 1'b1, 24'sd1, '0, 1'b1, 2'd3);
        send_item('0, '0, 1'b1, 24'sd4, '0, 1'b1, 2'd3);               // quotient tie
        send_item('0, '0, 1'b1, '0, '0, 1'b1, 2'd3);                   // negative step
        send_item(24'sd5000, '0, 1'b1, -24'sd5000, 24'sd77, 1'b0, 2'd0); // tag absent
        send_item(C_MIN, C_MIN, 1'b0, C_MAX, C_MAX, 1'b1, 2'd1);       // no state change
        send_item(-24'sd1, -24'sd1, 1'b1, C_MAX, C_MIN, 1'b1, 2'd3);
        send_item(C_MAX, C_MAX, 1'b1, C_MIN, C_MIN, 1'b0, 2'd2);
        send_item(C_MIN, '0, 1'b1, '0, C_MIN, 1'b1, 2'd1);

        for (int p = 0; p < 6; p++) begin
            setting = (p == 4) ? cnt_t'($urandom_range(2, 200)) : plan_cfg[p];
            write_max_samples(setting);
            if (p == 1) hold_req <= 1'b1;
            if (p == 5) quiet <= 1'b1;
            repeat (plan_items[p]) send_random_item();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0)
            $display("** tag_distance_running_mean_unit: PASSED **");
        else
            $display("** tag_distance_running_mean_unit: FAILED **");
        $finish;
    end

endmodule
